@@ src/fsweep_pkg.sv @@
package fsweep_pkg;

  localparam int FreqWidth  = 32;
  localparam int CountWidth = 4;
  localparam int OpWidth    = 3;
  localparam int CfgIdxWidth = 3;
  localparam int InDataWidth = 8;
  localparam int OutDataWidth = 40;

  typedef logic [FreqWidth-1:0]  freq_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [OpWidth-1:0] {
    OP_START       = 3'd0,
    OP_STOP        = 3'd1,
    OP_DWELL_TICK  = 3'd2,
    OP_LEVEL_CHECK = 3'd3,
    OP_CLEAR_RESCAN = 3'd4
  } op_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_START_FREQ  = 3'd0,
    REG_STOP_FREQ   = 3'd1,
    REG_STEP_FREQ   = 3'd2,
    REG_HIGH_NEEDED = 3'd3,
    REG_LOW_NEEDED  = 3'd4
  } cfg_reg_t;

  localparam freq_t  StartFreqReset  = 32'd800000;
  localparam freq_t  StopFreqReset   = 32'd1000000;
  localparam freq_t  StepFreqReset   = 32'd1000000;
  localparam count_t HighNeededReset = 4'd3;
  localparam count_t LowNeededReset  = 4'd10;

  typedef struct packed {
    logic  stable_level;
    logic  rescan_request;
    logic  halted_by_level;
    logic  is_finished;
    logic  is_running;
    logic  frequency_update;
    freq_t frequency;
  } result_t;

endpackage

@@ src/freq_sweep_with_level_stop_unit.sv @@
// A result appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle while the master side is ready; the single output register refills as it is read.
// Rate is set by the state update of frequency, flags and debounce counters.
// Reset (rst, synchronous, active high) restores the register defaults, clears all flags
// and debounce counters, loads the start frequency default and empties the output register.
module freq_sweep_with_level_stop_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] frequency, [32] frequency_update,
                                      // [33] is_running, [34] is_finished,
                                      // [35] halted_by_level, [36] rescan_request,
                                      // [37] stable_level, [39:38] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fsweep_pkg::freq_t  sweep_start;
  fsweep_pkg::freq_t  sweep_stop;
  fsweep_pkg::freq_t  sweep_step;
  fsweep_pkg::count_t high_needed;
  fsweep_pkg::count_t low_needed;

  fsweep_pkg::freq_t  cur_freq, cur_freq_next;
  logic running, running_next;
  logic finished, finished_next;
  logic level_halt, level_halt_next;
  logic rescan, rescan_next;
  logic prev_level, prev_level_next;
  fsweep_pkg::count_t high_count, high_count_next;
  fsweep_pkg::count_t low_count, low_count_next;

  fsweep_pkg::result_t result;
  fsweep_pkg::result_t result_next;

  logic in_accept;
  logic pin;
  logic update;
  logic deb_level;
  fsweep_pkg::count_t high_inc, low_inc;
  fsweep_pkg::count_t high_deb, low_deb;
  logic [fsweep_pkg::FreqWidth:0] tick_sum;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign pin           = s_axis_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_start <= fsweep_pkg::StartFreqReset;
      sweep_stop  <= fsweep_pkg::StopFreqReset;
      sweep_step  <= fsweep_pkg::StepFreqReset;
      high_needed <= fsweep_pkg::HighNeededReset;
      low_needed  <= fsweep_pkg::LowNeededReset;
    end else if (cfg_valid) begin
      case (fsweep_pkg::cfg_reg_t'(cfg_index))
        fsweep_pkg::REG_START_FREQ:  sweep_start <= cfg_data;
        fsweep_pkg::REG_STOP_FREQ:   sweep_stop  <= cfg_data;
        fsweep_pkg::REG_STEP_FREQ:   sweep_step  <= cfg_data;
        fsweep_pkg::REG_HIGH_NEEDED: high_needed <= cfg_data[fsweep_pkg::CountWidth-1:0];
        fsweep_pkg::REG_LOW_NEEDED:  low_needed  <= cfg_data[fsweep_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // Saturating debounce counters; the threshold check clamps an oversized count.
  always_comb begin
    if (pin) begin
      high_inc = (high_count < high_needed) ? high_count + 4'd1 : high_count;
      low_inc  = '0;
    end else begin
      high_inc = '0;
      low_inc  = (low_count < low_needed) ? low_count + 4'd1 : low_count;
    end
    high_deb  = high_inc;
    low_deb   = low_inc;
    deb_level = prev_level;
    if (high_inc >= high_needed) begin
      high_deb  = high_needed;
      deb_level = 1'b1;
    end else if (low_inc >= low_needed) begin
      low_deb   = low_needed;
      deb_level = 1'b0;
    end
  end

  assign tick_sum = {1'b0, cur_freq} + {1'b0, sweep_step};

  always_comb begin
    cur_freq_next   = cur_freq;
    running_next    = running;
    finished_next   = finished;
    level_halt_next = level_halt;
    rescan_next     = rescan;
    prev_level_next = prev_level;
    high_count_next = high_count;
    low_count_next  = low_count;
    update          = 1'b0;
    case (fsweep_pkg::op_t'(s_axis_tuser))
      fsweep_pkg::OP_START: begin
        cur_freq_next   = sweep_start;
        running_next    = 1'b1;
        finished_next   = 1'b0;
        level_halt_next = 1'b0;
        rescan_next     = 1'b0;
        prev_level_next = deb_level;
        high_count_next = high_deb;
        low_count_next  = low_deb;
        update          = 1'b1;
      end
      fsweep_pkg::OP_STOP: begin
        running_next = 1'b0;
      end
      fsweep_pkg::OP_DWELL_TICK: begin
        if (running) begin
          if (tick_sum > {1'b0, sweep_stop}) begin
            running_next  = 1'b0;
            finished_next = 1'b1;
          end else begin
            cur_freq_next = tick_sum[fsweep_pkg::FreqWidth-1:0];
            update        = 1'b1;
          end
        end
      end
      fsweep_pkg::OP_LEVEL_CHECK: begin
        high_count_next = high_deb;
        low_count_next  = low_deb;
        prev_level_next = deb_level;
        if (running) begin
          if (deb_level) begin
            running_next    = 1'b0;
            finished_next   = 1'b0;
            level_halt_next = 1'b1;
            rescan_next     = 1'b0;
          end
        end else if (level_halt && prev_level && !deb_level) begin
          rescan_next     = 1'b1;
          level_halt_next = 1'b0;
        end
      end
      fsweep_pkg::OP_CLEAR_RESCAN: begin
        rescan_next = 1'b0;
      end
      default: ;
    endcase
    result_next.frequency        = cur_freq_next;
    result_next.frequency_update = update;
    result_next.is_running       = running_next;
    result_next.is_finished      = finished_next;
    result_next.halted_by_level  = level_halt_next;
    result_next.rescan_request   = rescan_next;
    result_next.stable_level     = prev_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_freq      <= fsweep_pkg::StartFreqReset;
      running       <= 1'b0;
      finished      <= 1'b0;
      level_halt    <= 1'b0;
      rescan        <= 1'b0;
      prev_level    <= 1'b0;
      high_count    <= '0;
      low_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_accept) begin
        cur_freq   <= cur_freq_next;
        running    <= running_next;
        finished   <= finished_next;
        level_halt <= level_halt_next;
        rescan     <= rescan_next;
        prev_level <= prev_level_next;
        high_count <= high_count_next;
        low_count  <= low_count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = {2'b00, result};

`ifndef ASSERT_OFF
  a_run_fin_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(running && finished))
    else $error("sweep both running and finished");

  a_halt_rescan_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(level_halt && rescan))
    else $error("level halt and rescan request both set");

  a_update_while_running: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.frequency_update) |-> result.is_running)
    else $error("synthesizer update reported while not running");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (m_axis_tvalid && result.frequency == cur_freq))
    else $error("accepted request gave no matching result");
`endif

endmodule
